// ===== sv/als_pkg.sv =====
`default_nettype none
package als_pkg;

  localparam int TERM_W = 21;
  localparam int SCORE_W = 32;
  localparam int LEN_W = 12;
  localparam int LEN_MAX_FIELD = 4095;
  localparam int PROD_W = LEN_W + 1 + TERM_W;
  localparam int DELTA_W = PROD_W + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam int DEF_QUALITY_LEVELS = 128;
  localparam int DEF_MAX_DELETION = 4095;

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_GAP_OPEN = 1'b0;
  localparam logic REG_GAP_EXTEND = 1'b1;
  localparam logic signed [TERM_W-1:0] PENALTY_RESET = -21'sd65536;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned TENTH_ROOT40_Q30 = 64'd1013677651;
  localparam longint unsigned LOG10_2_Q32 = 64'd1292913986;
  localparam longint unsigned Q16_ONE = 64'd65536;
  localparam longint unsigned ERR_DIV = 64'd40;
  localparam longint unsigned ERR_ROUND = 64'd20;
  localparam logic signed [TERM_W-1:0] MATCH_FLOOR = -21'sd1048576;

  typedef enum logic [1:0] {
    EV_CLIP   = 2'd0,
    EV_MATCH  = 2'd1,
    EV_INSERT = 2'd2,
    EV_DELETE = 2'd3
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t          req_type;
    logic [7:0]        read_base;
    logic [7:0]        ref_code;
    logic [6:0]        base_quality;
    logic              first_in_run;
    logic [LEN_W-1:0]  deletion_length;
    logic              last_event;
  } in_item_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] alignment_score;
    logic signed [SCORE_W-1:0] best_possible_score;
    logic                      invalid_reference;
  } out_item_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] gap_open;
    logic signed [TERM_W-1:0] gap_extend;
  } pen_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic signed [TERM_W-1:0]  best_term;
    logic                      best_en;
    logic                      ref_bad;
    logic                      last;
  } job_t;

  function automatic logic signed [TERM_W-1:0] err_term_f(input int unsigned q);
    longint unsigned mag;
    mag = (longint'(q) * Q16_ONE + ERR_ROUND) / ERR_DIV;
    return TERM_W'(-$signed(mag));
  endfunction

  function automatic logic signed [TERM_W-1:0] match_term_f(input int unsigned q);
    longint unsigned x;
    longint unsigned y;
    longint unsigned k;
    longint unsigned f;
    longint unsigned n;
    longint unsigned mag;
    int unsigned i;
    x = ONE_Q30;
    y = 0;
    k = 0;
    f = 0;
    if (q == 0) begin
      return MATCH_FLOOR;
    end
    for (i = 1; i <= q; i++) begin
      x = (x * TENTH_ROOT40_Q30 + (64'd1 << 29)) >> 30;
    end
    y = ONE_Q30 - x;
    if (y == 0) begin
      return MATCH_FLOOR;
    end
    for (i = 0; i < 31; i++) begin
      if (y < ONE_Q30) begin
        y = y << 1;
        k = k + 1;
      end
    end
    for (i = 0; i < 24; i++) begin
      y = (y * y) >> 30;
      f = f << 1;
      if (y >= (ONE_Q30 << 1)) begin
        y = y >> 1;
        f = f | 64'd1;
      end
    end
    n = (k << 24) - f;
    mag = (n * LOG10_2_Q32 + (64'd1 << 39)) >> 40;
    return TERM_W'(-$signed(mag));
  endfunction

endpackage
`default_nettype wire

// ===== sv/alignment_log_likelihood_scorer.sv =====
// An accepted item is written into the queue and scored when it leaves it; its
// result, when it is the final item, is registered as it leaves the queue.
// Throughput: one item per cycle through a two-entry queue and one accumulator,
// unless a waiting result stalls a further final item, which holds items behind it.
// Reset (rst_n low, synchronous): clears sums, error flag, queue and result valid;
// gap penalties return to -1.0. The match table is constant, no fill pass.
`default_nettype none
module alignment_log_likelihood_scorer #(
  parameter int QUALITY_LEVELS = als_pkg::DEF_QUALITY_LEVELS,
  parameter int MAX_DELETION = als_pkg::DEF_MAX_DELETION
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire als_pkg::in_item_t            in_item,
  output logic                              out_valid,
  input  wire                               out_ready,
  output als_pkg::out_item_t                out_item,
  input  wire                               cfg_psel,
  input  wire                               cfg_penable,
  input  wire                               cfg_pwrite,
  input  wire [als_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire [31:0]                        cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import als_pkg::*;

  pen_t  pen_r;
  job_t  front_job;
  job_t  head_job;
  logic  q_full;
  logic  head_valid;
  logic  pop;
  logic  push;
  logic  cfg_wr;
  logic  reg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r.gap_open <= PENALTY_RESET;
      pen_r.gap_extend <= PENALTY_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_GAP_OPEN: pen_r.gap_open <= cfg_pwdata[TERM_W-1:0];
        REG_GAP_EXTEND: pen_r.gap_extend <= cfg_pwdata[TERM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_GAP_OPEN: cfg_prdata = 32'(pen_r.gap_open);
      REG_GAP_EXTEND: cfg_prdata = 32'(pen_r.gap_extend);
      default: cfg_prdata = '0;
    endcase
  end

  assign in_ready = !q_full;
  assign push = in_valid && in_ready;

  als_front #(
    .QUALITY_LEVELS(QUALITY_LEVELS),
    .MAX_DELETION(MAX_DELETION)
  ) u_front (
    .item(in_item),
    .pen(pen_r),
    .job(front_job)
  );

  als_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .push_job(front_job),
    .full(q_full),
    .pop(pop),
    .head_valid(head_valid),
    .head_job(head_job)
  );

  als_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .head_valid(head_valid),
    .head_job(head_job),
    .pop(pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

endmodule
`default_nettype wire

// ===== sv/als_front.sv =====
`default_nettype none
module als_front #(
  parameter int QUALITY_LEVELS = als_pkg::DEF_QUALITY_LEVELS,
  parameter int MAX_DELETION = als_pkg::DEF_MAX_DELETION
) (
  input  wire als_pkg::in_item_t item,
  input  wire als_pkg::pen_t     pen,
  output als_pkg::job_t          job
);
  import als_pkg::*;

  localparam int Q_W = (QUALITY_LEVELS > 1) ? $clog2(QUALITY_LEVELS) : 1;
  localparam int MAX_LEN = (MAX_DELETION > LEN_MAX_FIELD) ? LEN_MAX_FIELD : MAX_DELETION;

  logic signed [TERM_W-1:0] match_rom [QUALITY_LEVELS];
  logic signed [TERM_W-1:0] err_rom [QUALITY_LEVELS];

  for (genvar g = 0; g < QUALITY_LEVELS; g++) begin : g_rom
    localparam logic signed [TERM_W-1:0] MT = match_term_f(g);
    localparam logic signed [TERM_W-1:0] ET = err_term_f(g);
    assign match_rom[g] = MT;
    assign err_rom[g] = ET;
  end

  logic [6:0]               q_clamp;
  logic [Q_W-1:0]           q_idx;
  logic signed [TERM_W-1:0] m_term;
  logic signed [TERM_W-1:0] e_term;
  logic                     is_a, is_c, is_g, is_t;
  logic                     fits;
  logic                     code_ok;
  logic [LEN_W-1:0]         len_nz;
  logic [LEN_W-1:0]         len_eff;
  logic [LEN_W-1:0]         len_m1;
  logic signed [PROD_W-1:0] ext_prod;

  always_comb begin
    if (32'(item.base_quality) >= QUALITY_LEVELS) begin
      q_clamp = 7'(QUALITY_LEVELS - 1);
    end else begin
      q_clamp = item.base_quality;
    end
    q_idx = Q_W'(q_clamp);
    m_term = match_rom[q_idx];
    e_term = err_rom[q_idx];
  end

  always_comb begin
    is_a = item.read_base == "A";
    is_c = item.read_base == "C";
    is_g = item.read_base == "G";
    is_t = item.read_base == "T";
    code_ok = 1'b1;
    unique case (item.ref_code)
      "A": fits = is_a;
      "C": fits = is_c;
      "G": fits = is_g;
      "T": fits = is_t;
      "R": fits = is_a | is_g;
      "Y": fits = is_c | is_t;
      "S": fits = is_g | is_c;
      "W": fits = is_a | is_t;
      "K": fits = is_g | is_t;
      "M": fits = is_a | is_c;
      "B": fits = is_c | is_g | is_t;
      "D": fits = is_a | is_g | is_t;
      "H": fits = is_a | is_c | is_t;
      "V": fits = is_a | is_c | is_g;
      "N": fits = 1'b1;
      default: begin
        fits = 1'b0;
        code_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    len_nz = (item.deletion_length == '0) ? LEN_W'(1) : item.deletion_length;
    len_eff = (32'(len_nz) > MAX_LEN) ? LEN_W'(MAX_LEN) : len_nz;
    len_m1 = len_eff - LEN_W'(1);
    ext_prod = $signed({1'b0, len_m1}) * pen.gap_extend;
  end

  always_comb begin
    job.best_term = m_term;
    job.best_en = item.req_type != EV_DELETE;
    job.ref_bad = 1'b0;
    job.last = item.last_event;
    unique case (item.req_type)
      EV_CLIP: job.delta = DELTA_W'(e_term);
      EV_MATCH: begin
        job.delta = fits ? DELTA_W'(m_term) : DELTA_W'(e_term);
        job.ref_bad = !code_ok;
      end
      EV_INSERT: begin
        job.delta = DELTA_W'(e_term)
                  + DELTA_W'(item.first_in_run ? pen.gap_open : pen.gap_extend);
      end
      EV_DELETE: job.delta = DELTA_W'(pen.gap_open) + DELTA_W'(ext_prod);
      default: job.delta = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/als_queue.sv =====
`default_nettype none
module als_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  wire als_pkg::job_t push_job,
  output logic               full,
  input  wire                pop,
  output logic               head_valid,
  output als_pkg::job_t      head_job
);
  import als_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full = count_r == CNT_W'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head_valid))
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== sv/als_back.sv =====
`default_nettype none
module als_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    head_valid,
  input  wire als_pkg::job_t     head_job,
  output logic                   pop,
  output logic                   out_valid,
  input  wire                    out_ready,
  output als_pkg::out_item_t     out_item
);
  import als_pkg::*;

  localparam int SUM_W = DELTA_W + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'($signed(32'h7fffffff));
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'($signed(32'h80000000));

  function automatic logic signed [SCORE_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    if (v > SAT_HI) begin
      return SCORE_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      return SCORE_W'(SAT_LO);
    end
    return SCORE_W'(v);
  endfunction

  logic signed [SCORE_W-1:0] score_r, score_nxt;
  logic signed [SCORE_W-1:0] best_r, best_nxt;
  logic                      err_r, err_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_item_r;
  logic signed [SCORE_W-1:0] score_acc;
  logic signed [SCORE_W-1:0] best_acc;
  logic                      err_acc;

  assign pop = head_valid && (!head_job.last || !out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_item = out_item_r;

  always_comb begin
    score_acc = sat32(SUM_W'(score_r) + SUM_W'(head_job.delta));
    best_acc = head_job.best_en ? sat32(SUM_W'(best_r) + SUM_W'(head_job.best_term)) : best_r;
    err_acc = err_r | head_job.ref_bad;
    score_nxt = score_r;
    best_nxt = best_r;
    err_nxt = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (pop) begin
      if (head_job.last) begin
        score_nxt = '0;
        best_nxt = '0;
        err_nxt = 1'b0;
        out_valid_nxt = 1'b1;
      end else begin
        score_nxt = score_acc;
        best_nxt = best_acc;
        err_nxt = err_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r <= '0;
      best_r <= '0;
      err_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      score_r <= score_nxt;
      best_r <= best_nxt;
      err_r <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_job.last) begin
      out_item_r.alignment_score <= score_acc;
      out_item_r.best_possible_score <= best_acc;
      out_item_r.invalid_reference <= err_acc;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head_job.last |=> score_r == '0 && best_r == '0 && !err_r && out_valid_r)
    else $error("state not cleared after final item");

  a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !head_job.last && head_job.ref_bad |=> err_r)
    else $error("reference error flag lost");

  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(pop && head_job.last))
    else $error("result overwritten while waiting");

endmodule
`default_nettype wire

// ===== bench/alignment_log_likelihood_scorer_tb.sv =====
`default_nettype none
module alignment_log_likelihood_scorer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import als_pkg::*;

  localparam int QUAL_LEVELS = 128;
  localparam int DEL_MAX = 4095;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned ROOT40_Q30 = 64'd1013677651;
  localparam longint unsigned LOG2_Q32 = 64'd1292913986;
  localparam longint TERM_FLOOR = -64'sd1048576;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 6;
  localparam int PHASE_EVENTS = 238;
  localparam int CLIP_RUN = 200;

  class alignment_tally;
    longint quality_term[QUAL_LEVELS];
    longint run_score;
    longint run_best;
    bit ref_error;
    longint open_pen;
    longint extend_pen;
    out_item_t pending_scores[$];
    int mismatches;

    function new();
      longint unsigned x;
      longint unsigned p;
      longint unsigned k;
      longint unsigned f;
      longint unsigned n;
      x = Q30_ONE;
      quality_term[0] = TERM_FLOOR;
      for (int q = 1; q < QUAL_LEVELS; q++) begin
        x = (x * ROOT40_Q30 + (64'd1 << 29)) >> 30;
        p = Q30_ONE - x;
        if (p == 0) begin
          quality_term[q] = TERM_FLOOR;
        end else begin
          k = 0;
          f = 0;
          while (p < Q30_ONE) begin
            p = p << 1;
            k++;
          end
          for (int i = 0; i < 24; i++) begin
            p = (p * p) >> 30;
            f = f << 1;
            if (p >= (Q30_ONE << 1)) begin
              p = p >> 1;
              f = f | 64'd1;
            end
          end
          n = (k << 24) - f;
          quality_term[q] = -longint'((n * LOG2_Q32 + (64'd1 << 39)) >> 40);
        end
      end
      run_score = 0;
      run_best = 0;
      ref_error = 0;
      open_pen = -65536;
      extend_pen = -65536;
      mismatches = 0;
    endfunction

    function longint clamp32(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    function void set_penalty(logic idx, logic [31:0] word);
      if (idx == REG_GAP_OPEN) open_pen = longint'($signed(word[20:0]));
      else extend_pen = longint'($signed(word[20:0]));
    endfunction

    function void code_fits(logic [7:0] b, logic [7:0] r, output bit fits, output bit known);
      bit a;
      bit c;
      bit g;
      bit t;
      a = (b == "A");
      c = (b == "C");
      g = (b == "G");
      t = (b == "T");
      known = 1;
      case (r)
        "A": fits = a;
        "C": fits = c;
        "G": fits = g;
        "T": fits = t;
        "R": fits = a || g;
        "Y": fits = c || t;
        "S": fits = g || c;
        "W": fits = a || t;
        "K": fits = g || t;
        "M": fits = a || c;
        "B": fits = c || g || t;
        "D": fits = a || g || t;
        "H": fits = a || c || t;
        "V": fits = a || c || g;
        "N": fits = 1;
        default: begin
          fits = 0;
          known = 0;
        end
      endcase
    endfunction

    function void note_event(in_item_t ev);
      int q;
      longint err;
      longint mt;
      longint delta;
      longint len;
      bit fits;
      bit known;
      out_item_t e;
      q = ev.base_quality;
      if (q >= QUAL_LEVELS) q = QUAL_LEVELS - 1;
      err = -((longint'(q) * 65536 + 20) / 40);
      mt = quality_term[q];
      case (ev.req_type)
        EV_CLIP: delta = err;
        EV_MATCH: begin
          code_fits(ev.read_base, ev.ref_code, fits, known);
          if (!known) ref_error = 1;
          delta = fits ? mt : err;
        end
        EV_INSERT: delta = err + (ev.first_in_run ? open_pen : extend_pen);
        default: begin
          len = ev.deletion_length;
          if (len > DEL_MAX) len = DEL_MAX;
          delta = open_pen;
          if (len > 1) delta += (len - 1) * extend_pen;
        end
      endcase
      run_score = clamp32(run_score + delta);
      if (ev.req_type != EV_DELETE) run_best = clamp32(run_best + mt);
      if (ev.last_event) begin
        e.alignment_score = run_score[31:0];
        e.best_possible_score = run_best[31:0];
        e.invalid_reference = ref_error;
        pending_scores = {pending_scores, e};
        run_score = 0;
        run_best = 0;
        ref_error = 0;
      end
    endfunction

    function void check_score(out_item_t got);
      out_item_t e;
      if (pending_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected score: %0d best %0d flag %0b", got.alignment_score,
                   got.best_possible_score, got.invalid_reference);
        return;
      end
      e = pending_scores.pop_front();
      if (got.alignment_score !== e.alignment_score ||
          got.best_possible_score !== e.best_possible_score ||
          got.invalid_reference !== e.invalid_reference) begin
        mismatches++;
        if (mismatches <= 10)
          $display("score differs: exp %0d/%0d/%0b got %0d/%0d/%0b",
                   e.alignment_score, e.best_possible_score, e.invalid_reference,
                   got.alignment_score, got.best_possible_score, got.invalid_reference);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_item;
  logic out_valid;
  logic out_ready;
  out_item_t out_item;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  alignment_tally tally = new();
  string base_set = "ACGT";
  string code_set = "ACGTRYSWKMBDHVN";
  int send_calm;
  int take_calm;
  int results_taken;
  int quiet_cycles;

  alignment_log_likelihood_scorer uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #2 clk = ~clk;

  function automatic int idle_draw(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic in_item_t ev_make(ev_kind_t kind, logic [7:0] base, logic [7:0] code,
                                       int q, bit first, int len, bit last);
    in_item_t ev;
    ev.req_type = kind;
    ev.read_base = base;
    ev.ref_code = code;
    ev.base_quality = 7'(q);
    ev.first_in_run = first;
    ev.deletion_length = 12'(len);
    ev.last_event = last;
    return ev;
  endfunction

  function automatic in_item_t random_event(bit prev_ins, bit last);
    in_item_t ev;
    int pick;
    pick = $urandom_range(0, 99);
    ev.req_type = pick < 15 ? EV_CLIP : pick < 65 ? EV_MATCH : pick < 85 ? EV_INSERT : EV_DELETE;
    if ($urandom_range(0, 9) == 0) ev.read_base = 8'($urandom());
    else ev.read_base = base_set[$urandom_range(0, 3)];
    pick = $urandom_range(0, 19);
    if (pick < 8) ev.ref_code = ev.read_base;
    else if (pick < 17) ev.ref_code = code_set[$urandom_range(0, 14)];
    else ev.ref_code = 8'($urandom());
    ev.base_quality = 7'($urandom());
    if (ev.req_type == EV_INSERT)
      ev.first_in_run = ($urandom_range(0, 9) == 0) ? prev_ins : !prev_ins;
    else
      ev.first_in_run = 1'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 70) ev.deletion_length = 12'($urandom_range(1, 8));
    else if (pick < 90) ev.deletion_length = 12'($urandom());
    else ev.deletion_length = $urandom_range(0, 1) ? 12'd0 : 12'd4095;
    ev.last_event = last;
    return ev;
  endfunction

  task automatic push_event(input in_item_t ev);
    int gap;
    gap = idle_draw(send_calm);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item = ev;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    tally.note_event(ev);
    @(negedge clk);
  endtask

  task automatic send_alignment(input int events);
    bit prev_ins;
    in_item_t ev;
    prev_ins = 0;
    for (int i = 0; i < events; i++) begin
      ev = random_event(prev_ins, i == events - 1);
      prev_ins = (ev.req_type == EV_INSERT);
      push_event(ev);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] word);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = word;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    if (cfg_pready) tally.set_penalty(idx, word);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (tally.pending_scores.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_directed();
    push_event(ev_make(EV_CLIP, "A", "A", 0, 0, 1, 0));
    push_event(ev_make(EV_CLIP, "C", "A", 127, 0, 1, 0));
    push_event(ev_make(EV_MATCH, "A", "A", 127, 0, 1, 0));
    push_event(ev_make(EV_MATCH, "C", "N", 0, 0, 1, 0));
    push_event(ev_make(EV_MATCH, "a", "A", 20, 0, 1, 0));
    push_event(ev_make(EV_MATCH, "G", "R", 33, 0, 1, 0));
    push_event(ev_make(EV_MATCH, "T", "R", 33, 0, 1, 0));
    push_event(ev_make(EV_INSERT, "G", "A", 40, 1, 1, 0));
    push_event(ev_make(EV_INSERT, "T", "A", 10, 0, 1, 0));
    push_event(ev_make(EV_DELETE, "A", "A", 0, 1, 0, 0));
    push_event(ev_make(EV_DELETE, "A", "A", 0, 0, 1, 0));
    push_event(ev_make(EV_DELETE, "A", "A", 0, 0, 4095, 1));
    push_event(ev_make(EV_MATCH, "T", "x", 5, 0, 1, 0));
    push_event(ev_make(EV_MATCH, "C", "n", 5, 1, 1, 0));
    push_event(ev_make(EV_INSERT, "A", "A", 127, 1, 1, 1));
    push_event(ev_make(EV_MATCH, 8'hFF, 8'hFF, 127, 1, 4095, 1));
    push_event(ev_make(EV_MATCH, 8'h00, 8'h00, 0, 0, 0, 0));
    push_event(ev_make(EV_DELETE, "A", "A", 127, 0, 2, 1));
    push_event(ev_make(EV_MATCH, "A", "B", 60, 0, 1, 0));
    push_event(ev_make(EV_MATCH, "C", "V", 90, 0, 1, 1));
    for (int i = 0; i < CLIP_RUN; i++)
      push_event(ev_make(EV_CLIP, "A", "A", 0, 0, 1, i == CLIP_RUN - 1));
  endtask

  initial begin
    int sent;
    int n;
    logic [31:0] open_word;
    logic [31:0] ext_word;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_calm = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        settle();
        case (phase)
          1: begin
            open_word = 32'hFFF0_0000;
            ext_word = 32'h7A10_0000;
          end
          2: begin
            open_word = 32'h0;
            ext_word = 32'h0;
          end
          3: begin
            open_word = 32'h000F_FFFF;
            ext_word = 32'h800F_FFFF;
          end
          default: begin
            open_word = ($urandom_range(0, 3) == 0) ? $urandom() : -$urandom_range(0, 1048576);
            ext_word = ($urandom_range(0, 3) == 0) ? $urandom() : -$urandom_range(0, 1048576);
          end
        endcase
        write_reg(REG_GAP_OPEN, open_word);
        write_reg(REG_GAP_EXTEND, ext_word);
      end
      push_event(ev_make(EV_DELETE, "A", "A", 0, 0, 4095, 0));
      push_event(ev_make(EV_DELETE, "A", "A", 0, 1, 4095, 0));
      push_event(ev_make(EV_CLIP, "G", "G", 127, 0, 1, 1));
      sent = 0;
      while (sent < PHASE_EVENTS) begin
        n = $urandom_range(1, 12);
        send_alignment(n);
        sent += n;
      end
    end
    in_valid = 1'b0;
    while (tally.pending_scores.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tally.mismatches == 0 && tally.pending_scores.size() == 0)
      $display("alignment_log_likelihood_scorer: match");
    else
      $display("alignment_log_likelihood_scorer: mismatch");
    $finish;
  end

  initial begin
    int gap;
    out_ready = 1'b0;
    take_calm = 0;
    results_taken = 0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      gap = idle_draw(take_calm);
      if (results_taken == 40 || results_taken == 150) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      results_taken++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tally.check_score(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("alignment_log_likelihood_scorer: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
`default_nettype wire
